[sv/tqrt_pkg.sv]
// Shared constants, codes and types for the two-queue retransmit timer.
// Used by tqrt_alu and two_queue_retransmit_timer_top; depends on nothing.
package tqrt_pkg;

  // Pool and field sizes.
  localparam int SLOT_COUNT  = 32;
  localparam int SLOT_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OWNER_BITS  = 8;
  localparam int MAX_RESULTS = 32;
  localparam int COUNT_BITS  = $clog2(SLOT_COUNT + 1);
  localparam int RES_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int TIME_BITS   = 32;
  localparam int TOUT_BITS   = 16;
  localparam int CTX_BITS    = 8;
  localparam int HANDLE_BITS = 5;
  localparam int EV_BITS     = 3;

  // Free-slot scan looks at one group of slots per cycle.
  localparam int GROUP_W    = 8;
  localparam int PE_BITS    = $clog2(GROUP_W);
  localparam int GROUPS     = (SLOT_COUNT + GROUP_W - 1) / GROUP_W;
  localparam int GRP_BITS   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PAD_W      = GROUPS * GROUP_W;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  // Result event codes.
  typedef enum logic [EV_BITS-1:0] {
    EV_STARTED   = 3'd0,
    EV_START_REJ = 3'd1,
    EV_STOPPED   = 3'd2,
    EV_STOP_REJ  = 3'd3,
    EV_EXPIRED   = 3'd4,
    EV_NO_EXPIRY = 3'd5
  } ev_t;

  // Shared adder operation.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_ALLOC,
    ST_STOP,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_TICK_END
  } state_t;

endpackage

[sv/tqrt_alu.sv]
// Shared 32-bit add/subtract unit of the retransmit timer.
// Depends on tqrt_pkg for the operation code and time width.
module tqrt_alu (
  input  logic [tqrt_pkg::TIME_BITS-1:0] a,
  input  logic [tqrt_pkg::TIME_BITS-1:0] b,
  input  tqrt_pkg::alu_op_t              op,
  output logic [tqrt_pkg::TIME_BITS-1:0] sum,
  output logic                           carry
);
  import tqrt_pkg::*;

  logic [TIME_BITS-1:0] b_eff;
  logic [TIME_BITS:0]   full;

  // Subtraction is a + ~b + 1; carry out set means a >= b unsigned.
  always_comb begin
    b_eff = (op == ALU_SUB) ? ~b : b;
    full  = {1'b0, a} + {1'b0, b_eff} + {{TIME_BITS{1'b0}}, (op == ALU_SUB)};
    sum   = full[TIME_BITS-1:0];
    carry = full[TIME_BITS];
  end

endmodule

[sv/two_queue_retransmit_timer_top.sv]
// Two-queue retransmit timer: slot pool, two linked timer queues, sequencer.
// Depends on tqrt_pkg and instantiates the shared adder tqrt_alu.
// Start: ST_FIND scans 1 to 4 free-slot groups, then ST_ALLOC stores the slot;
// a full pool is rejected once the last group is scanned. A start or stop with
// an unknown kind is answered in the cycle after accept and never raises busy.
// Stop: ST_STOP answers. Tick: ST_TICK_RD reads a queue's head, ST_TICK_CMP
// checks it, again per expired head, then ST_TICK_END closes; every expiry costs
// one adder use. busy is high from the cycle after accept until the last word
// is registered; the receiver cannot stall the block.
// Reset (rst, synchronous) empties both queues and frees all slots; slot memory
// keeps its contents and is only read for slots in use.
module two_queue_retransmit_timer_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [1:0]                       action,
  input  logic [1:0]                       timer_kind,
  input  logic [tqrt_pkg::TOUT_BITS-1:0]   timeout,
  input  logic [tqrt_pkg::CTX_BITS-1:0]    context_id,
  input  logic [tqrt_pkg::HANDLE_BITS-1:0] handle,
  input  logic [tqrt_pkg::TIME_BITS-1:0]   current_time,
  output logic                             busy,
  output logic                             result_valid,
  output logic [tqrt_pkg::EV_BITS-1:0]     event_res,
  output logic [tqrt_pkg::HANDLE_BITS-1:0] slot,
  output logic                             kind_out,
  output logic [tqrt_pkg::CTX_BITS-1:0]    owner,
  output logic                             last
);
  import tqrt_pkg::*;

  // Sequencer and latched request.
  state_t                 state, state_next;
  logic                   kind_r, kind_r_next;
  logic [TOUT_BITS-1:0]   tout_r, tout_r_next;
  logic [OWNER_BITS-1:0]  ctx_r, ctx_r_next;
  logic [HANDLE_BITS-1:0] hnd_r, hnd_r_next;
  logic [TIME_BITS-1:0]   now_r, now_r_next;
  logic [GRP_BITS-1:0]    grp, grp_next;
  logic [SLOT_BITS-1:0]   free_slot, free_slot_next;
  logic                   q, q_next;
  logic [RES_BITS-1:0]    n_res, n_res_next;

  // Expiry held back one step so the final word can carry last.
  logic                   pend_valid, pend_valid_next;
  logic [SLOT_BITS-1:0]   pend_slot, pend_slot_next;
  logic                   pend_kind, pend_kind_next;
  logic [OWNER_BITS-1:0]  pend_owner, pend_owner_next;

  // Queue bookkeeping.
  logic [SLOT_COUNT-1:0]  used, used_next;
  logic [SLOT_BITS-1:0]   head [2];
  logic [SLOT_BITS-1:0]   head_next [2];
  logic [SLOT_BITS-1:0]   tail [2];
  logic [SLOT_BITS-1:0]   tail_next [2];
  logic [COUNT_BITS-1:0]  count [2];
  logic [COUNT_BITS-1:0]  count_next [2];

  // Result register next values.
  logic                   result_valid_next;
  logic [EV_BITS-1:0]     event_res_next;
  logic [HANDLE_BITS-1:0] slot_next;
  logic                   kind_out_next;
  logic [CTX_BITS-1:0]    owner_next;
  logic                   last_next;

  // Slot memories: deadline, owner, queue, and the two link fields.
  logic [TIME_BITS-1:0]   dl_mem [SLOT_COUNT];
  logic [OWNER_BITS-1:0]  ow_mem [SLOT_COUNT];
  logic                   qu_mem [SLOT_COUNT];
  logic [SLOT_BITS-1:0]   nx_mem [SLOT_COUNT];
  logic [SLOT_BITS-1:0]   pv_mem [SLOT_COUNT];
  logic [TIME_BITS-1:0]   dl_rd;
  logic [OWNER_BITS-1:0]  ow_rd;
  logic                   qu_rd;
  logic [SLOT_BITS-1:0]   nx_rd;
  logic [SLOT_BITS-1:0]   pv_rd;
  logic [SLOT_BITS-1:0]   rd_addr;
  logic                   slot_we;
  logic [SLOT_BITS-1:0]   slot_wa;
  logic                   nx_we;
  logic [SLOT_BITS-1:0]   nx_wa;
  logic [SLOT_BITS-1:0]   nx_wd;
  logic                   pv_we;
  logic [SLOT_BITS-1:0]   pv_wa;
  logic [SLOT_BITS-1:0]   pv_wd;

  // Shared adder.
  logic [TIME_BITS-1:0]   alu_b;
  alu_op_t                alu_op;
  logic [TIME_BITS-1:0]   alu_sum;
  logic                   alu_carry;

  // Free-slot scan.
  logic [PAD_W-1:0]       used_pad;
  logic [GROUP_W-1:0]     grp_bits;
  logic [PE_BITS-1:0]     pe;
  logic                   grp_free;
  logic [SLOT_BITS-1:0]   found_slot;

  logic                   accept;
  logic                   kind_ok;
  logic                   stop_ok;
  logic [SLOT_BITS-1:0]   hslot;
  logic                   due;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign kind_ok = !timer_kind[1];
  assign stop_ok = kind_ok && (32'(handle) < SLOT_COUNT);
  assign hslot   = SLOT_BITS'(hnd_r);
  assign due     = alu_carry;

  tqrt_alu u_alu (
    .a     (now_r),
    .b     (alu_b),
    .op    (alu_op),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // Slots past the pool end read as taken.
  generate
    if (PAD_W == SLOT_COUNT) begin : g_nopad
      assign used_pad = used;
    end else begin : g_pad
      assign used_pad = {{(PAD_W - SLOT_COUNT){1'b1}}, used};
    end
  endgenerate

  // Lowest free slot within the current group.
  always_comb begin
    grp_bits = used_pad[grp * GROUP_W +: GROUP_W];
    pe       = '0;
    grp_free = 1'b0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        pe       = PE_BITS'(i);
        grp_free = 1'b1;
      end
    end
    found_slot = SLOT_BITS'({grp, pe});
  end

  // Adder operand selection.
  always_comb begin
    if (state == ST_TICK_CMP) begin
      alu_b  = dl_rd;
      alu_op = ALU_SUB;
    end else begin
      alu_b  = TIME_BITS'(tout_r);
      alu_op = ALU_ADD;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_START: if (kind_ok) state_next = ST_FIND;
            ACT_STOP:  if (stop_ok) state_next = ST_STOP;
            ACT_TICK:  state_next = ST_TICK_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_FIND: begin
        if (grp_free) begin
          state_next = ST_ALLOC;
        end else if (grp == GRP_BITS'(GROUPS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_ALLOC: state_next = ST_IDLE;
      ST_STOP:  state_next = ST_IDLE;
      ST_TICK_RD: begin
        if (count[q] != '0) begin
          state_next = ST_TICK_CMP;
        end else if (q) begin
          state_next = ST_TICK_END;
        end
      end
      ST_TICK_CMP: begin
        if (due) begin
          state_next = (n_res == RES_BITS'(MAX_RESULTS - 1)) ? ST_TICK_END : ST_TICK_RD;
        end else begin
          state_next = q ? ST_TICK_END : ST_TICK_RD;
        end
      end
      ST_TICK_END: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Datapath, memory write controls and result words.
  always_comb begin
    kind_r_next       = kind_r;
    tout_r_next       = tout_r;
    ctx_r_next        = ctx_r;
    hnd_r_next        = hnd_r;
    now_r_next        = now_r;
    grp_next          = grp;
    free_slot_next    = free_slot;
    q_next            = q;
    n_res_next        = n_res;
    pend_valid_next   = pend_valid;
    pend_slot_next    = pend_slot;
    pend_kind_next    = pend_kind;
    pend_owner_next   = pend_owner;
    used_next         = used;
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    result_valid_next = 1'b0;
    event_res_next    = event_res;
    slot_next         = slot;
    kind_out_next     = kind_out;
    owner_next        = owner;
    last_next         = 1'b0;
    rd_addr           = head[q];
    slot_we           = 1'b0;
    slot_wa           = free_slot;
    nx_we             = 1'b0;
    nx_wa             = tail[kind_r];
    nx_wd             = free_slot;
    pv_we             = 1'b0;
    pv_wa             = free_slot;
    pv_wd             = tail[kind_r];

    unique case (state)
      ST_IDLE: begin
        rd_addr = SLOT_BITS'(handle);
        if (accept) begin
          kind_r_next     = timer_kind[0];
          tout_r_next     = timeout;
          ctx_r_next      = OWNER_BITS'(context_id);
          hnd_r_next      = handle;
          now_r_next      = current_time;
          grp_next        = '0;
          q_next          = 1'b0;
          n_res_next      = '0;
          pend_valid_next = 1'b0;
          // Unknown kind or bad handle is answered at once.
          if (action == ACT_START && !kind_ok) begin
            result_valid_next = 1'b1;
            event_res_next    = EV_START_REJ;
            slot_next         = '0;
            kind_out_next     = 1'b0;
            owner_next        = '0;
            last_next         = 1'b1;
          end else if (action == ACT_STOP && !stop_ok) begin
            result_valid_next = 1'b1;
            event_res_next    = EV_STOP_REJ;
            slot_next         = handle;
            kind_out_next     = 1'b0;
            owner_next        = '0;
            last_next         = 1'b1;
          end
        end
      end

      ST_FIND: begin
        grp_next = grp + 1'b1;
        if (grp_free) begin
          free_slot_next = found_slot;
        end else if (grp == GRP_BITS'(GROUPS - 1)) begin
          // Pool is full.
          result_valid_next = 1'b1;
          event_res_next    = EV_START_REJ;
          slot_next         = '0;
          kind_out_next     = 1'b0;
          owner_next        = '0;
          last_next         = 1'b1;
        end
      end

      ST_ALLOC: begin
        // Store the slot and append it at the tail of its queue.
        slot_we = 1'b1;
        pv_we   = 1'b1;
        if (count[kind_r] != '0) begin
          nx_we = 1'b1;
        end else begin
          head_next[kind_r] = free_slot;
        end
        tail_next[kind_r]  = free_slot;
        count_next[kind_r] = count[kind_r] + 1'b1;
        used_next[free_slot] = 1'b1;
        result_valid_next  = 1'b1;
        event_res_next     = EV_STARTED;
        slot_next          = HANDLE_BITS'(free_slot);
        kind_out_next      = kind_r;
        owner_next         = CTX_BITS'(ctx_r);
        last_next          = 1'b1;
      end

      ST_STOP: begin
        result_valid_next = 1'b1;
        last_next         = 1'b1;
        if (used[hslot] && qu_rd == kind_r) begin
          // Unlink from the neighbors, or move head and tail.
          if (hslot == head[kind_r]) begin
            head_next[kind_r] = nx_rd;
          end else begin
            nx_we = 1'b1;
            nx_wa = pv_rd;
            nx_wd = nx_rd;
          end
          if (hslot == tail[kind_r]) begin
            tail_next[kind_r] = pv_rd;
          end else begin
            pv_we = 1'b1;
            pv_wa = nx_rd;
            pv_wd = pv_rd;
          end
          count_next[kind_r] = count[kind_r] - 1'b1;
          used_next[hslot]   = 1'b0;
          event_res_next     = EV_STOPPED;
          slot_next          = hnd_r;
          kind_out_next      = kind_r;
          owner_next         = CTX_BITS'(ow_rd);
        end else begin
          event_res_next = EV_STOP_REJ;
          slot_next      = hnd_r;
          kind_out_next  = 1'b0;
          owner_next     = '0;
        end
      end

      ST_TICK_RD: begin
        // Empty first queue moves straight on to the second.
        if (count[q] == '0 && !q) begin
          q_next = 1'b1;
        end
      end

      ST_TICK_CMP: begin
        if (due) begin
          // Release the held word and hold this expiry in its place.
          if (pend_valid) begin
            result_valid_next = 1'b1;
            event_res_next    = EV_EXPIRED;
            slot_next         = HANDLE_BITS'(pend_slot);
            kind_out_next     = pend_kind;
            owner_next        = CTX_BITS'(pend_owner);
          end
          pend_valid_next  = 1'b1;
          pend_slot_next   = head[q];
          pend_kind_next   = q;
          pend_owner_next  = ow_rd;
          head_next[q]     = nx_rd;
          count_next[q]    = count[q] - 1'b1;
          used_next[head[q]] = 1'b0;
          n_res_next       = n_res + 1'b1;
        end else if (!q) begin
          q_next = 1'b1;
        end
      end

      ST_TICK_END: begin
        result_valid_next = 1'b1;
        last_next         = 1'b1;
        if (pend_valid) begin
          event_res_next = EV_EXPIRED;
          slot_next      = HANDLE_BITS'(pend_slot);
          kind_out_next  = pend_kind;
          owner_next     = CTX_BITS'(pend_owner);
        end else begin
          event_res_next = EV_NO_EXPIRY;
          slot_next      = '0;
          kind_out_next  = 1'b0;
          owner_next     = '0;
        end
      end

      default: begin
        result_valid_next = 1'b0;
      end
    endcase
  end

  // Slot memories with registered reads.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      dl_mem[slot_wa] <= alu_sum;
      ow_mem[slot_wa] <= ctx_r;
      qu_mem[slot_wa] <= kind_r;
    end
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    dl_rd <= dl_mem[rd_addr];
    ow_rd <= ow_mem[rd_addr];
    qu_rd <= qu_mem[rd_addr];
    nx_rd <= nx_mem[rd_addr];
    pv_rd <= pv_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      used         <= '0;
      count[0]     <= '0;
      count[1]     <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      last         <= 1'b0;
    end else begin
      state        <= state_next;
      used         <= used_next;
      count        <= count_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
      last         <= last_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_r_next;
    tout_r     <= tout_r_next;
    ctx_r      <= ctx_r_next;
    hnd_r      <= hnd_r_next;
    now_r      <= now_r_next;
    grp        <= grp_next;
    free_slot  <= free_slot_next;
    q          <= q_next;
    n_res      <= n_res_next;
    pend_slot  <= pend_slot_next;
    pend_kind  <= pend_kind_next;
    pend_owner <= pend_owner_next;
    head       <= head_next;
    tail       <= tail_next;
    event_res  <= event_res_next;
    slot       <= slot_next;
    kind_out   <= kind_out_next;
    owner      <= owner_next;
  end

  // Every slot in use sits in exactly one queue.
  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == (int'(count[0]) + int'(count[1])))
    else $error("queue counts disagree with slots in use");

  // The closing step of a tick always delivers the final word.
  a_tick_end_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK_END) |=> (result_valid && last))
    else $error("tick closed without a final word");

  // A word that is not final means the block is still working.
  a_more_words_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("non-final word while idle");

endmodule

[tb/sv/two_queue_retransmit_timer_top_tb.sv]
// Self-checking testbench for the two-queue retransmit timer block.
// Depends on tqrt_pkg and two_queue_retransmit_timer_top; a scoreboard class
// predicts every result word and checks the block's output stream against it.
module two_queue_retransmit_timer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tqrt_pkg::*;

  // Timer kind codes as carried on the timer_kind port.
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_BAD2   = 2'd2;
  localparam logic [1:0] KIND_BAD3   = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MIX_ITEMS      = 80;
  localparam int FILL_ITEMS     = SLOT_COUNT + 2;
  localparam int CALM_TAIL      = 25;

  // One result word as the block presents it.
  typedef struct {
    ev_t                    ev;
    logic [HANDLE_BITS-1:0] slot;
    logic                   kind;
    logic [CTX_BITS-1:0]    owner;
    logic                   last;
  } timer_word_t;

  // Timer pool model and store of result words not yet seen.
  class timer_scoreboard;
    bit                   live[SLOT_COUNT];
    logic [TIME_BITS-1:0] due_time[SLOT_COUNT];
    logic [CTX_BITS-1:0]  tag[SLOT_COUNT];
    logic                 which_q[SLOT_COUNT];
    // Live slots in start order; each kind's queue is this list filtered by kind.
    int                   arrival[$];
    timer_word_t          pending_words[$];
    int                   errors;
    int                   words_in;
    int                   results_seen;
    int                   expiries;
    int                   rejects;

    function void push_word(ev_t ev, int s, logic k, logic [CTX_BITS-1:0] o);
      timer_word_t w;
      w.ev    = ev;
      w.slot  = s[HANDLE_BITS-1:0];
      w.kind  = k;
      w.owner = o;
      w.last  = 1'b0;
      pending_words.push_back(w);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", what);
    endfunction

    // Returns a random slot that holds a running timer, or -1 if none does.
    function int live_slot();
      int picks[$];
      for (int i = 0; i < SLOT_COUNT; i++) if (live[i]) picks.push_back(i);
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    // Apply one accepted input word to the pool and queue up its results.
    function void note_input(logic [1:0] act, logic [1:0] kind,
                             logic [TOUT_BITS-1:0] tout, logic [CTX_BITS-1:0] ctx,
                             logic [HANDLE_BITS-1:0] hdl, logic [TIME_BITS-1:0] now);
      int s;
      int pos;
      int n;
      bit hit;
      s = -1;
      pos = -1;
      n = 0;
      if (act != ACT_NONE) words_in++;
      case (act)
        ACT_START: begin
          // Lowest free slot wins; unknown kinds never get one.
          if (kind <= KIND_SECOND) begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--) if (!live[i]) s = i;
          end
          if (s < 0) begin
            push_word(EV_START_REJ, 0, 1'b0, '0);
            rejects++;
          end else begin
            live[s]     = 1'b1;
            due_time[s] = now + tout;
            tag[s]      = ctx;
            which_q[s]  = kind[0];
            arrival.push_back(s);
            push_word(EV_STARTED, s, kind[0], ctx);
          end
        end
        ACT_STOP: begin
          if (kind <= KIND_SECOND && live[hdl] && which_q[hdl] == kind[0]) begin
            for (int i = 0; i < arrival.size(); i++) if (arrival[i] == hdl) pos = i;
          end
          if (pos < 0) begin
            push_word(EV_STOP_REJ, hdl, 1'b0, '0);
            rejects++;
          end else begin
            arrival.delete(pos);
            live[hdl] = 1'b0;
            push_word(EV_STOPPED, hdl, kind[0], tag[hdl]);
          end
        end
        ACT_TICK: begin
          // Drain due heads, first queue before second, never past a head not due.
          for (int qi = 0; qi < 2; qi++) begin
            hit = 1'b1;
            while (hit && n < MAX_RESULTS) begin
              pos = -1;
              for (int j = 0; j < arrival.size(); j++) begin
                if (pos < 0 && which_q[arrival[j]] == qi[0]) pos = j;
              end
              if (pos < 0) begin
                hit = 1'b0;
              end else begin
                s = arrival[pos];
                if (due_time[s] > now) begin
                  hit = 1'b0;
                end else begin
                  arrival.delete(pos);
                  live[s] = 1'b0;
                  push_word(EV_EXPIRED, s, qi[0], tag[s]);
                  n++;
                  expiries++;
                end
              end
            end
          end
          if (n == 0) push_word(EV_NO_EXPIRY, 0, 1'b0, '0);
        end
        default: ;
      endcase
      if (act != ACT_NONE) pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    // Compare one result word with the oldest one still pending.
    function void check_result(logic [EV_BITS-1:0] ev, logic [HANDLE_BITS-1:0] s,
                               logic k, logic [CTX_BITS-1:0] o, logic l);
      timer_word_t w;
      results_seen++;
      if (pending_words.size() == 0) begin
        flag($sformatf("unexpected word ev=%0d slot=%0d kind=%0d owner=%0h last=%0d",
                       ev, s, k, o, l));
      end else begin
        w = pending_words.pop_front();
        if (w.ev !== ev || w.slot !== s || w.kind !== k || w.owner !== o ||
            w.last !== l) begin
          flag($sformatf("exp ev=%0d slot=%0d kind=%0d owner=%0h last=%0d, got %0d %0d %0d %0h %0d",
                         w.ev, w.slot, w.kind, w.owner, w.last, ev, s, k, o, l));
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic [1:0]             action;
  logic [1:0]             timer_kind;
  logic [TOUT_BITS-1:0]   timeout;
  logic [CTX_BITS-1:0]    context_id;
  logic [HANDLE_BITS-1:0] handle;
  logic [TIME_BITS-1:0]   current_time;
  logic                   busy;
  logic                   result_valid;
  logic [EV_BITS-1:0]     event_res;
  logic [HANDLE_BITS-1:0] slot;
  logic                   kind_out;
  logic [CTX_BITS-1:0]    owner;
  logic                   last;

  timer_scoreboard        sb;
  int                     quiet_cycles;
  logic [TIME_BITS-1:0]   tick_now;

  two_queue_retransmit_timer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .action       (action),
    .timer_kind   (timer_kind),
    .timeout      (timeout),
    .context_id   (context_id),
    .handle       (handle),
    .current_time (current_time),
    .busy         (busy),
    .result_valid (result_valid),
    .event_res    (event_res),
    .slot         (slot),
    .kind_out     (kind_out),
    .owner        (owner),
    .last         (last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Check every result word and count cycles in which nothing moves.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(event_res, slot, kind_out, owner, last);
    if (!rst && (result_valid || (start && !busy))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: a stalled block ends the run.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Present one word at the falling edge and hold it until the block takes it.
  task automatic send_word(input logic [1:0] act, input logic [1:0] kind,
                           input logic [TOUT_BITS-1:0] tout,
                           input logic [CTX_BITS-1:0] ctx,
                           input logic [HANDLE_BITS-1:0] hdl,
                           input logic [TIME_BITS-1:0] now);
    bit taken;
    taken = 1'b0;
    @(negedge clk);
    start        <= 1'b1;
    action       <= act;
    timer_kind   <= kind;
    timeout      <= tout;
    context_id   <= ctx;
    handle       <= hdl;
    current_time <= now;
    while (!taken) begin
      @(posedge clk);
      if (!busy) taken = 1'b1;
    end
    sb.note_input(act, kind, tout, ctx, hdl, now);
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Random sender gap, taken after about three words in ten.
  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 9) < 3) idle($urandom_range(1, 9));
  endtask

  // Hold off the sender until every pending word has come back.
  task automatic drain();
    idle(1);
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  // Main stimulus sequence.
  initial begin
    int                     pick;
    int                     s;
    logic [1:0]             kind;
    logic [TOUT_BITS-1:0]   tout;
    logic [TIME_BITS-1:0]   base;
    sb           = new();
    quiet_cycles = 0;
    rst          = 1'b1;
    start        = 1'b0;
    action       = ACT_TICK;
    timer_kind   = KIND_FIRST;
    timeout      = '0;
    context_id   = '0;
    handle       = '0;
    current_time = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty tick, field extremes, every rejection path but a full pool.
    send_word(ACT_TICK, KIND_FIRST, 16'd0, 8'd0, 5'd0, 32'd0);
    send_word(ACT_START, KIND_FIRST, 16'd0, 8'h00, 5'd0, 32'd0);
    send_word(ACT_START, KIND_SECOND, 16'hFFFF, 8'hFF, 5'd31, 32'hFFFF_FFFF);
    send_word(ACT_START, KIND_BAD2, 16'd7, 8'h11, 5'd0, 32'd10);
    maybe_idle(1'b1);
    send_word(ACT_START, KIND_BAD3, 16'd7, 8'h22, 5'd0, 32'd10);
    send_word(ACT_STOP, KIND_FIRST, 16'd0, 8'd0, 5'd1, 32'd0);
    send_word(ACT_STOP, KIND_SECOND, 16'd0, 8'd0, 5'd31, 32'd0);
    send_word(ACT_STOP, KIND_BAD2, 16'd0, 8'd0, 5'd0, 32'd0);
    send_word(ACT_STOP, KIND_BAD3, 16'd0, 8'd0, 5'd1, 32'd0);
    send_word(ACT_START, KIND_FIRST, 16'd5, 8'hA5, 5'd0, 32'd100);
    send_word(ACT_START, KIND_FIRST, 16'd10, 8'h5A, 5'd0, 32'd100);
    // Stop from the middle of a queue; the freed slot is reused at the tail.
    send_word(ACT_STOP, KIND_FIRST, 16'd0, 8'd0, 5'd2, 32'd0);
    send_word(ACT_START, KIND_FIRST, 16'd1, 8'h3C, 5'd0, 32'd100);
    send_word(ACT_NONE, KIND_SECOND, 16'hFFFF, 8'hFF, 5'd31, 32'hFFFF_FFFF);
    // Only heads are examined: a later entry that is due waits behind one that is not.
    send_word(ACT_TICK, KIND_FIRST, 16'd0, 8'd0, 5'd0, 32'd105);
    maybe_idle(1'b1);
    send_word(ACT_TICK, KIND_FIRST, 16'd0, 8'd0, 5'd0, 32'hFFFF_FFFF);
    send_word(ACT_STOP, KIND_SECOND, 16'd0, 8'd0, 5'd1, 32'd0);
    // Expiry exactly at the deadline.
    send_word(ACT_START, KIND_SECOND, 16'd0, 8'h81, 5'd0, 32'd500);
    send_word(ACT_TICK, KIND_FIRST, 16'd0, 8'd0, 5'd0, 32'd500);
    send_word(ACT_TICK, KIND_FIRST, 16'd0, 8'd0, 5'd0, 32'hFFFF_FFFF);

    // Fill the whole pool, overflow it, then expire every timer in one tick.
    base = $urandom_range(0, 32'hFFFE_0000);
    for (int i = 0; i < FILL_ITEMS; i++) begin
      send_word(ACT_START, 2'($urandom_range(0, 1)), 16'($urandom_range(1, 65535)),
                8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), base);
      maybe_idle(1'b1);
    end
    drain();
    send_word(ACT_TICK, KIND_FIRST, 16'd0, 8'd0, 5'd0, base + 32'h0001_0000);

    // Mixed traffic with a slowly advancing clock and rare jumps.
    tick_now = $urandom;
    for (int i = 0; i < MIX_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 3) tick_now = $urandom;
      else tick_now = tick_now + $urandom_range(0, 20);
      if ($urandom_range(0, 99) < 15) tout = 16'($urandom_range(0, 65535));
      else tout = 16'($urandom_range(0, 60));
      if ($urandom_range(0, 9) == 0) kind = 2'($urandom_range(2, 3));
      else kind = 2'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_word(ACT_START, kind, tout, 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), tick_now);
      end else if (pick < 65) begin
        s = sb.live_slot();
        if (s >= 0 && $urandom_range(0, 4) != 0)
          send_word(ACT_STOP, {1'b0, sb.which_q[s]}, tout, 8'($urandom_range(0, 255)),
                    5'(s), tick_now);
        else
          send_word(ACT_STOP, 2'($urandom_range(0, 3)), tout, 8'($urandom_range(0, 255)),
                    5'($urandom_range(0, 31)), tick_now);
      end else if (pick < 95) begin
        send_word(ACT_TICK, kind, tout, 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), tick_now);
      end else begin
        send_word(ACT_NONE, kind, tout, 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), tick_now);
      end
      if (i == MIX_ITEMS / 2) drain();
      maybe_idle(i < MIX_ITEMS - CALM_TAIL);
    end

    // Wait for the last words, then let any stray output show up.
    drain();
    repeat (100) @(posedge clk);

    $display("Run covered %0d words in and %0d results out.", sb.words_in, sb.results_seen);
    $display("Timers expired: %0d, requests rejected: %0d.", sb.expiries, sb.rejects);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tqrt_pkg.sv
sv/tqrt_alu.sv
sv/two_queue_retransmit_timer_top.sv
tb/sv/two_queue_retransmit_timer_top_tb.sv
